/* rtl/blq_pkg.sv */
// Shared widths, codes, thresholds and types of the battery level qualifier.
package blq_pkg;

    // Check framing.
    localparam int SAMPLES_AVERAGED  = 10;
    localparam int SAMPLES_DISCARDED = 2;
    localparam int CHECK_LEN         = SAMPLES_DISCARDED + SAMPLES_AVERAGED;
    localparam int IDX_W             = (CHECK_LEN > 1) ? $clog2(CHECK_LEN) : 1;

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int AVG_W    = 10;
    localparam int LVL_W    = 3;
    localparam int CNT_W    = 8;
    localparam int NEED_W   = 5;
    localparam int PERIOD_W = 15;
    localparam int TICK_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = TICK_W;
    localparam int SUM_W    = $clog2(SAMPLES_AVERAGED * ((1 << SAMPLE_W) - 1) + 1);

    // Exact division of the sum by the number of kept samples:
    // avg = (sum * DIV_MULT) >> DIV_SHIFT with a rounded-up reciprocal.
    localparam int DIV_L     = $clog2(SAMPLES_AVERAGED);
    localparam int DIV_SHIFT = SUM_W + DIV_L;
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam int DIV_MULT  = ((1 << DIV_SHIFT) + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED;
    localparam int PROD_W    = SUM_W + MULT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREVER = 1'd1;

    // Level codes.
    localparam logic [LVL_W-1:0] LV_BLANK = 3'd0;
    localparam logic [LVL_W-1:0] LV_ONE   = 3'd1;
    localparam logic [LVL_W-1:0] LV_TWO   = 3'd2;
    localparam logic [LVL_W-1:0] LV_THREE = 3'd3;
    localparam logic [LVL_W-1:0] LV_CUT   = 3'd4;

    // Classification thresholds on the average.
    localparam logic [AVG_W-1:0] TH_CUT      = 10'h2e6;
    localparam logic [AVG_W-1:0] TH_BLANK    = 10'h308;
    localparam logic [AVG_W-1:0] TH_ONE      = 10'h325;
    localparam logic [AVG_W-1:0] TH_TWO      = 10'h348;
    localparam logic [AVG_W-1:0] TH_CUT_NEAR = TH_CUT + 10'h6;
    localparam logic [AVG_W-1:0] TH_CUT_LOW  = TH_CUT + 10'h8;
    localparam logic [AVG_W-1:0] TH_CUT_MID  = TH_CUT + 10'hd;

    // Repeat counts needed to confirm a level.
    localparam logic [NEED_W-1:0] NEED_NONE   = 5'd0;
    localparam logic [NEED_W-1:0] NEED_SHORT  = 5'd5;
    localparam logic [NEED_W-1:0] NEED_MID    = 5'd10;
    localparam logic [NEED_W-1:0] NEED_NORMAL = 5'd15;
    localparam logic [NEED_W-1:0] NEED_MUSIC  = 5'd30;

    // Low clock periods in ticks.
    localparam logic [CNT_W-1:0]    LOW_TICKS       = 8'd168;
    localparam logic [CNT_W-1:0]    LOW_TICKS_HALF  = 8'd84;
    localparam logic [CNT_W-1:0]    LOW_TICKS_SHORT = 8'd34;
    localparam logic [PERIOD_W-1:0] PERIOD_LOW_CUT  = 15'd10;
    localparam logic [PERIOD_W-1:0] PERIOD_LOW_BAR  = 15'd504;

    // Tick register clamping and reset values of the derived periods.
    localparam logic [TICK_W-1:0]   TICK_MIN   = 11'd1;
    localparam logic [TICK_W-1:0]   TICK_MAX   = 11'd1024;
    localparam logic [TICK_W-1:0]   TICK_RST   = 11'd100;
    localparam logic [PERIOD_W-1:0] T1_RST     = 15'd100;
    localparam logic [PERIOD_W-1:0] T2_RST     = 15'd200;
    localparam logic [PERIOD_W-1:0] T30_RST    = 15'd3000;

    typedef struct packed {
        logic [LVL_W-1:0] confirmed;
        logic [LVL_W-1:0] pending;
        logic [LVL_W-1:0] previous;
        logic [CNT_W-1:0] repeat_count;
        logic [CNT_W-1:0] low_count;
        logic             first_check;
        logic [CNT_W-1:0] blank_low;
        logic             blank_two;
    } t_lvl_state;

    localparam t_lvl_state LVL_STATE_RST = '{
        confirmed:    LV_THREE,
        pending:      LV_THREE,
        previous:     LV_CUT,
        repeat_count: '0,
        low_count:    '0,
        first_check:  1'b1,
        blank_low:    LOW_TICKS_HALF,
        blank_two:    1'b0
    };

    typedef struct packed {
        logic [LVL_W-1:0]    level;
        logic [LVL_W-1:0]    tentative_level;
        logic [AVG_W-1:0]    average;
        logic [PERIOD_W-1:0] next_period;
        logic                shutdown_request;
        logic                checked;
    } t_result;

    // Check periods in high clock mode, derived once from the tick register.
    typedef struct packed {
        logic [PERIOD_W-1:0] t1;
        logic [PERIOD_W-1:0] t2;
        logic [PERIOD_W-1:0] t30;
    } t_periods;

endpackage

/* rtl/blq_if.sv */
// Handshake channels of the battery level qualifier: samples, configuration and results.
interface blq_smp_if;
    logic                          valid;
    logic                          ready;
    logic [blq_pkg::SAMPLE_W-1:0]  sample;
    logic                          reduced_clock;
    logic                          music_playing;
    logic                          sleep_active;

    modport source (output valid, output sample, output reduced_clock, output music_playing,
                    output sleep_active, input ready);
    modport sink   (input valid, input sample, input reduced_clock, input music_playing,
                    input sleep_active, output ready);
endinterface

interface blq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [blq_pkg::CFG_IDX_W-1:0]   index;
    logic [blq_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface blq_res_if;
    logic                          valid;
    logic                          ready;
    logic [blq_pkg::LVL_W-1:0]     level;
    logic [blq_pkg::LVL_W-1:0]     tentative_level;
    logic [blq_pkg::AVG_W-1:0]     average;
    logic [blq_pkg::PERIOD_W-1:0]  next_period;
    logic                          shutdown_request;
    logic                          checked;

    modport source (output valid, output level, output tentative_level, output average,
                    output next_period, output shutdown_request, output checked,
                    input ready);
    modport sink   (input valid, input level, input tentative_level, input average,
                    input next_period, input shutdown_request, input checked,
                    output ready);
endinterface

/* rtl/battery_level_qualifier.sv */
// Top level of the battery level qualifier: sample accumulation, check stage and result register.
// One sample request is taken per cycle while no finished check is held back by back-pressure on the
// result channel; samples that do not end a check give no result. A check's final sample loads the
// check register, and the check result then moves into the result register when that one is free or read.
// Throughput is one sample per cycle, limited only by back-pressure on the result channel.
// Reset (synchronous, active low) clears the sample count and sum, restores the level state
// and the configuration registers; there is no clearing pass.
module battery_level_qualifier (
    input  logic          i_clk,
    input  logic          i_rst_n,
    blq_smp_if.sink       i_smp,
    blq_cfg_if.sink       i_cfg,
    blq_res_if.source     o_res
);

    // Configuration.
    logic                         r_forever;
    blq_pkg::t_periods            r_periods;
    logic [blq_pkg::TICK_W-1:0]   cfg_t;
    logic [blq_pkg::PERIOD_W:0]   cfg_t32;
    logic [blq_pkg::PERIOD_W:0]   cfg_t2w;

    // Sample accumulation.
    logic [blq_pkg::IDX_W-1:0]    r_idx;
    logic [blq_pkg::SUM_W-1:0]    r_sum;
    logic [blq_pkg::SUM_W-1:0]    sum_in;
    logic                         kept;
    logic                         last;
    logic                         smp_acc;

    // Check stage.
    logic                         r_chk_valid;
    logic [blq_pkg::SUM_W-1:0]    r_chk_sum;
    logic                         r_chk_reduced_clock;
    logic                         r_chk_music;
    logic                         r_chk_sleep;
    logic                         advance;
    blq_pkg::t_lvl_state          r_state;
    blq_pkg::t_lvl_state          n_state;
    blq_pkg::t_result             n_result;

    // Result register.
    logic                         r_out_valid;
    blq_pkg::t_result             r_result;

    assign i_cfg.ready = 1'b1;

    // Clamp the tick count and derive the high clock periods at write time.
    always_comb begin
        if (i_cfg.data < blq_pkg::TICK_MIN) begin
            cfg_t = blq_pkg::TICK_MIN;
        end else if (i_cfg.data > blq_pkg::TICK_MAX) begin
            cfg_t = blq_pkg::TICK_MAX;
        end else begin
            cfg_t = i_cfg.data;
        end
    end
    assign cfg_t32 = (blq_pkg::PERIOD_W + 1)'(cfg_t) << 5;
    assign cfg_t2w = (blq_pkg::PERIOD_W + 1)'(cfg_t) << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_forever     <= 1'b0;
            r_periods.t1  <= blq_pkg::T1_RST;
            r_periods.t2  <= blq_pkg::T2_RST;
            r_periods.t30 <= blq_pkg::T30_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                blq_pkg::CFG_TICKS: begin
                    r_periods.t1  <= blq_pkg::PERIOD_W'(cfg_t);
                    r_periods.t2  <= cfg_t2w[blq_pkg::PERIOD_W-1:0];
                    r_periods.t30 <= blq_pkg::PERIOD_W'(cfg_t32 - cfg_t2w);
                end
                blq_pkg::CFG_FOREVER: begin
                    r_forever <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshakes.
    assign advance     = r_chk_valid && (!r_out_valid || o_res.ready);
    assign i_smp.ready = !r_chk_valid || advance;
    assign smp_acc     = i_smp.valid && i_smp.ready;

    assign kept   = r_idx >= blq_pkg::IDX_W'(blq_pkg::SAMPLES_DISCARDED);
    assign last   = r_idx == blq_pkg::IDX_W'(blq_pkg::CHECK_LEN - 1);
    assign sum_in = r_sum + (kept ? blq_pkg::SUM_W'(i_smp.sample) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_sum       <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (smp_acc) begin
                if (last) begin
                    r_idx <= '0;
                    r_sum <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    r_sum <= sum_in;
                end
            end
            if (smp_acc && last) begin
                r_chk_valid <= 1'b1;
            end else if (advance) begin
                r_chk_valid <= 1'b0;
            end
        end
    end

    // Payload of the check register.
    always_ff @(posedge i_clk) begin
        if (smp_acc && last) begin
            r_chk_sum           <= sum_in;
            r_chk_reduced_clock <= i_smp.reduced_clock;
            r_chk_music         <= i_smp.music_playing;
            r_chk_sleep         <= i_smp.sleep_active;
        end
    end

    blq_check u_check (
        .i_sum           (r_chk_sum),
        .i_reduced_clock (r_chk_reduced_clock),
        .i_music         (r_chk_music),
        .i_sleep         (r_chk_sleep),
        .i_check_forever (r_forever),
        .i_periods       (r_periods),
        .i_state         (r_state),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blq_pkg::LVL_STATE_RST;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.level            = r_result.level;
    assign o_res.tentative_level  = r_result.tentative_level;
    assign o_res.average          = r_result.average;
    assign o_res.next_period      = r_result.next_period;
    assign o_res.shutdown_request = r_result.shutdown_request;
    assign o_res.checked          = r_result.checked;

`ifndef SYNTHESIS
    // The sample counter never runs past the last sample of a check.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= blq_pkg::IDX_W'(blq_pkg::CHECK_LEN - 1))
        else $error("sample index out of range");

    // A shutdown request comes only with a confirmed cutoff level.
    a_shut_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.shutdown_request |-> o_res.level == blq_pkg::LV_CUT)
        else $error("shutdown without cutoff level");

    // A skipped check reports a zero average and no shutdown.
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.checked |-> o_res.average == '0 && !o_res.shutdown_request)
        else $error("skipped check with nonzero payload");

    // A check held back by a full result register stays in the check stage.
    a_chk_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid && !advance |=> r_chk_valid && $stable(r_chk_sum))
        else $error("stalled check lost");

    // Once confirmed at cutoff, the level stays at cutoff.
    a_cut_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.confirmed == blq_pkg::LV_CUT |=> r_state.confirmed == blq_pkg::LV_CUT)
        else $error("level left cutoff");
`endif

endmodule

/* rtl/blq_check.sv */
// Per-check logic: average of the kept samples, level classification and qualification.
module blq_check (
    input  logic [blq_pkg::SUM_W-1:0] i_sum,
    input  logic                      i_reduced_clock,
    input  logic                      i_music,
    input  logic                      i_sleep,
    input  logic                      i_check_forever,
    input  blq_pkg::t_periods         i_periods,
    input  blq_pkg::t_lvl_state       i_state,
    output blq_pkg::t_lvl_state       o_state,
    output blq_pkg::t_result          o_result
);

    function automatic logic [blq_pkg::CNT_W-1:0] sat_inc(input logic [blq_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    localparam logic [blq_pkg::MULT_W-1:0] DIV_MULT_V = blq_pkg::MULT_W'(blq_pkg::DIV_MULT);

    logic [blq_pkg::PROD_W-1:0]   prod;
    logic [blq_pkg::AVG_W-1:0]    avg;
    logic                         skip;
    logic [blq_pkg::NEED_W-1:0]   need;
    logic [blq_pkg::CNT_W-1:0]    rc;
    logic                         shut;
    blq_pkg::t_lvl_state          n_st;
    logic [blq_pkg::PERIOD_W-1:0] period;

    assign prod = blq_pkg::PROD_W'(i_sum) * blq_pkg::PROD_W'(DIV_MULT_V);
    assign avg  = prod[blq_pkg::DIV_SHIFT +: blq_pkg::AVG_W];

    // A check is skipped at cutoff, or after the first one unless checking forever.
    assign skip = (i_state.confirmed == blq_pkg::LV_CUT) ||
                  (!i_check_forever && !i_state.first_check);

    always_comb begin
        n_st = i_state;
        need = blq_pkg::NEED_NONE;
        rc   = '0;
        shut = 1'b0;
        if (!skip) begin
            need = i_music ? blq_pkg::NEED_MUSIC : blq_pkg::NEED_NORMAL;
            if (avg > blq_pkg::TH_TWO) begin
                n_st.pending   = blq_pkg::LV_THREE;
                n_st.low_count = '0;
            end else if (avg > blq_pkg::TH_ONE) begin
                n_st.pending   = blq_pkg::LV_TWO;
                n_st.low_count = '0;
            end else if (avg > blq_pkg::TH_BLANK) begin
                n_st.pending   = blq_pkg::LV_ONE;
                n_st.low_count = '0;
            end else if (!i_reduced_clock && avg > blq_pkg::TH_CUT) begin
                n_st.pending = blq_pkg::LV_BLANK;
                if (avg <= blq_pkg::TH_CUT_NEAR) begin
                    n_st.blank_low = blq_pkg::LOW_TICKS_HALF;
                    n_st.blank_two = 1'b1;
                    need           = blq_pkg::NEED_SHORT;
                end
                n_st.low_count = '0;
            end else if (i_reduced_clock && avg > blq_pkg::TH_CUT_LOW) begin
                n_st.pending   = blq_pkg::LV_BLANK;
                n_st.blank_two = 1'b1;
                n_st.blank_low = blq_pkg::LOW_TICKS;
                if (avg <= blq_pkg::TH_CUT_MID) begin
                    if (i_music) begin
                        need = blq_pkg::NEED_MID;
                    end else begin
                        n_st.blank_low = blq_pkg::LOW_TICKS_HALF;
                        need           = blq_pkg::NEED_SHORT;
                    end
                end
                n_st.low_count = '0;
            end else begin
                // Cutoff band: shutdown on the third low check in a row.
                need = blq_pkg::NEED_NONE;
                if (!i_state.first_check && !i_sleep) begin
                    if (i_state.low_count > 8'd1) begin
                        n_st.confirmed = blq_pkg::LV_CUT;
                        n_st.pending   = blq_pkg::LV_CUT;
                        shut           = 1'b1;
                    end
                    n_st.low_count = sat_inc(i_state.low_count);
                end else begin
                    n_st.low_count = '0;
                    n_st.confirmed = blq_pkg::LV_BLANK;
                    n_st.pending   = blq_pkg::LV_BLANK;
                end
                if (i_reduced_clock) begin
                    n_st.blank_low = blq_pkg::LOW_TICKS_SHORT;
                end
            end
            if (need != blq_pkg::NEED_NONE) begin
                rc = (i_state.previous == n_st.pending) ? sat_inc(i_state.repeat_count) : '0;
                if (rc >= blq_pkg::CNT_W'(need)) begin
                    n_st.confirmed = n_st.pending;
                    rc             = '0;
                end
                if (i_state.first_check) begin
                    n_st.confirmed   = n_st.pending;
                    n_st.first_check = 1'b0;
                end
                n_st.repeat_count = rc;
                n_st.previous     = n_st.pending;
            end
        end
    end

    // The next period follows the state left by this check.
    always_comb begin
        if (!i_reduced_clock) begin
            if (n_st.confirmed == blq_pkg::LV_CUT) begin
                period = i_periods.t1;
            end else if (n_st.confirmed != blq_pkg::LV_BLANK) begin
                period = i_periods.t30;
            end else begin
                period = n_st.blank_two ? i_periods.t2 : i_periods.t1;
            end
        end else begin
            if (n_st.confirmed == blq_pkg::LV_CUT) begin
                period = blq_pkg::PERIOD_LOW_CUT;
            end else if (n_st.confirmed != blq_pkg::LV_BLANK) begin
                period = blq_pkg::PERIOD_LOW_BAR;
            end else begin
                period = blq_pkg::PERIOD_W'(n_st.blank_low);
            end
        end
    end

    assign o_state                   = n_st;
    assign o_result.level            = n_st.confirmed;
    assign o_result.tentative_level  = n_st.pending;
    assign o_result.average          = skip ? '0 : avg;
    assign o_result.next_period      = period;
    assign o_result.shutdown_request = shut;
    assign o_result.checked          = !skip;

endmodule
